// ===== rtl/core/multibrot_escape_time_defines.svh =====
// assertion macros shared by the multibrot escape-time block
`ifndef MULTIBROT_ESCAPE_TIME_DEFINES_SVH
`define MULTIBROT_ESCAPE_TIME_DEFINES_SVH

// same-cycle implication on clk, off while rst_n is low
`define MBET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define MBET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mbet_pkg.sv =====
// shared constants, types and helpers for the multibrot escape-time block
package mbet_pkg;

    // word widths
    localparam int PIXEL_BITS = 12;
    localparam int ITER_BITS  = 16;
    localparam int LIMIT_REG_W = 16;
    localparam int LIMIT_BITS = (ITER_BITS < LIMIT_REG_W) ? ITER_BITS : LIMIT_REG_W;
    localparam int FRAC_BITS  = 28;
    localparam int WORD_W     = 32;
    localparam int STEP_W     = 31;
    localparam int EXP_W      = 7;
    localparam int PCNT_W     = 6;
    localparam int OPND_W     = 33;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int PSH_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_POWER  = 64;

    localparam logic signed [SUM_W-1:0] FOUR_Q = SUM_W'(4) << FRAC_BITS;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT   = 3'd5;

    // register reset values
    localparam logic signed [WORD_W-1:0] RST_REAL_MIN  = 32'shE000_0000;
    localparam logic signed [WORD_W-1:0] RST_IMAG_MIN  = 32'shE000_0000;
    localparam logic [STEP_W-1:0]        RST_STEP      = 31'h0004_0000;
    localparam logic [LIMIT_REG_W-1:0]   RST_LIMIT     = 16'd100;
    localparam logic [EXP_W-1:0]         RST_EXPONENT  = 7'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_CHECK,
        ST_CMUL,
        ST_ADDC,
        ST_MAG
    } mbet_state_t;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } mbet_mul_req_t;

    // clamp a wide signed sum to 32 bits
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic all_same;
        all_same = (v[SUM_W-1:WORD_W-1] == '0) || (v[SUM_W-1:WORD_W-1] == '1);
        if (all_same)
            return v[WORD_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/core/mbet_mul.sv =====
// shared signed multiplier with registered product
module mbet_mul
    import mbet_pkg::*;
(
    input  logic                     clk,
    input  mbet_mul_req_t            req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // one product per cycle, available the cycle after issue
    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/multibrot_escape_time.sv =====
// multibrot escape time: one pixel at a time through a shared multiplier sequencer
// steps: the coordinate, then per iteration a chain of p-1 complex multiplies (p = exponent
// clamped to 1..64), z = p + c and |z|^2, and one final check; the result strobe follows.
// one pixel in flight; start is taken again in the result cycle. the multiplier port (one
// product per cycle) is the shared resource that paces the sequencer.
// reset: config registers to defaults, sequencer idles; the result is shown one cycle.
`include "multibrot_escape_time_defines.svh"

module multibrot_escape_time
    import mbet_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // pixel command
    input  logic                        start,
    output logic                        busy,
    input  logic [PIXEL_BITS-1:0]       pixel_col,
    input  logic [PIXEL_BITS-1:0]       pixel_row,
    // result
    output logic                        done,
    output logic [15:0]                 iter_count,
    output logic                        escaped,
    output logic signed [WORD_W-1:0]    excess_magnitude,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [WORD_W-1:0]           cfg_data
);

    // configuration registers
    logic signed [WORD_W-1:0]  real_min_reg;
    logic signed [WORD_W-1:0]  imag_min_reg;
    logic [STEP_W-1:0]         real_step_reg;
    logic [STEP_W-1:0]         imag_step_reg;
    logic [LIMIT_REG_W-1:0]    iter_limit_reg;
    logic [EXP_W-1:0]          exponent_reg;

    // sequencer and datapath
    mbet_state_t               state_reg, state_next;
    logic [2:0]                phase_reg, phase_next;
    logic [PIXEL_BITS-1:0]     col_reg, col_next;
    logic [PIXEL_BITS-1:0]     row_reg, row_next;
    logic signed [WORD_W-1:0]  cr_reg, cr_next;
    logic signed [WORD_W-1:0]  ci_reg, ci_next;
    logic signed [WORD_W-1:0]  zr_reg, zr_next;
    logic signed [WORD_W-1:0]  zi_reg, zi_next;
    logic signed [WORD_W-1:0]  pr_reg, pr_next;
    logic signed [WORD_W-1:0]  pi_reg, pi_next;
    logic signed [WORD_W-1:0]  re_tmp_reg, re_tmp_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic signed [SUM_W-1:0]   mag_reg, mag_next;
    logic [LIMIT_BITS-1:0]     iter_reg, iter_next;
    logic [PCNT_W-1:0]         pcount_reg, pcount_next;

    // result word
    logic                      done_reg, done_next;
    logic [15:0]               iter_count_reg, iter_count_next;
    logic                      escaped_reg, escaped_next;
    logic signed [WORD_W-1:0]  excess_reg, excess_next;

    mbet_mul_req_t             mul_req;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PSH_W-1:0]   prod_sh;
    logic signed [SUM_W-1:0]   prod_sx;
    logic signed [SUM_W-1:0]   coord_prod;
    logic [LIMIT_BITS-1:0]     limit;
    logic [PCNT_W-1:0]         mul_count;
    logic                      mag_big;

    mbet_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // product views: shifted with floor rounding, and the raw low part for coordinates
    assign prod_sh    = prod[PROD_W-1:FRAC_BITS];
    assign prod_sx    = SUM_W'(prod_sh);
    assign coord_prod = prod[SUM_W-1:0];

    assign limit   = iter_limit_reg[LIMIT_BITS-1:0];
    assign mag_big = (mag_reg >= FOUR_Q);

    // multiplies per iteration: exponent clamped to 1..64, minus one
    always_comb
    begin
        if (exponent_reg == '0)
            mul_count = '0;
        else if (exponent_reg > EXP_W'(MAX_POWER))
            mul_count = PCNT_W'(MAX_POWER - 1);
        else
            mul_count = PCNT_W'(exponent_reg - EXP_W'(1));
    end

    // configuration write channel never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_min_reg   <= RST_REAL_MIN;
            imag_min_reg   <= RST_IMAG_MIN;
            real_step_reg  <= RST_STEP;
            imag_step_reg  <= RST_STEP;
            iter_limit_reg <= RST_LIMIT;
            exponent_reg   <= RST_EXPONENT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_REAL_MIN:   real_min_reg   <= cfg_data;
                REG_IMAG_MIN:   imag_min_reg   <= cfg_data;
                REG_REAL_STEP:  real_step_reg  <= cfg_data[STEP_W-1:0];
                REG_IMAG_STEP:  imag_step_reg  <= cfg_data[STEP_W-1:0];
                REG_ITER_LIMIT: iter_limit_reg <= cfg_data[LIMIT_REG_W-1:0];
                REG_EXPONENT:   exponent_reg   <= cfg_data[EXP_W-1:0];
                default:        ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        row_reg        <= row_next;
        cr_reg         <= cr_next;
        ci_reg         <= ci_next;
        zr_reg         <= zr_next;
        zi_reg         <= zi_next;
        pr_reg         <= pr_next;
        pi_reg         <= pi_next;
        re_tmp_reg     <= re_tmp_next;
        acc_reg        <= acc_next;
        mag_reg        <= mag_next;
        iter_reg       <= iter_next;
        pcount_reg     <= pcount_next;
        iter_count_reg <= iter_count_next;
        escaped_reg    <= escaped_next;
        excess_reg     <= excess_next;
    end

    // sequencer: issue at most one product per phase, consume the one issued a phase earlier
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cr_next         = cr_reg;
        ci_next         = ci_reg;
        zr_next         = zr_reg;
        zi_next         = zi_reg;
        pr_next         = pr_reg;
        pi_next         = pi_reg;
        re_tmp_next     = re_tmp_reg;
        acc_next        = acc_reg;
        mag_next        = mag_reg;
        iter_next       = iter_reg;
        pcount_next     = pcount_reg;
        done_next       = 1'b0;
        iter_count_next = iter_count_reg;
        escaped_next    = escaped_reg;
        excess_next     = excess_reg;
        mul_req.a       = '0;
        mul_req.b       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    col_next   = pixel_col;
                    row_next   = pixel_row;
                    zr_next    = '0;
                    zi_next    = '0;
                    mag_next   = '0;
                    iter_next  = '0;
                    phase_next = '0;
                    state_next = ST_COORD;
                end
            end

            // c = min + pixel * step, exact then clamped
            ST_COORD:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        mul_req.a  = {1'b0, real_step_reg};
                        mul_req.b  = OPND_W'(col_reg);
                        phase_next = 3'd1;
                    end
                    3'd1:
                    begin
                        mul_req.a  = {1'b0, imag_step_reg};
                        mul_req.b  = OPND_W'(row_reg);
                        cr_next    = sat32(SUM_W'(real_min_reg) + coord_prod);
                        phase_next = 3'd2;
                    end
                    default:
                    begin
                        ci_next    = sat32(SUM_W'(imag_min_reg) + coord_prod);
                        phase_next = '0;
                        state_next = ST_CHECK;
                    end
                endcase
            end

            // loop test, and start of the next power chain
            ST_CHECK:
            begin
                pr_next     = zr_reg;
                pi_next     = zi_reg;
                pcount_next = mul_count;
                phase_next  = '0;
                if (mag_big || (iter_reg >= limit))
                begin
                    done_next       = 1'b1;
                    iter_count_next = 16'(iter_reg);
                    escaped_next    = mag_big;
                    excess_next     = sat32(mag_reg - FOUR_Q);
                    state_next      = ST_IDLE;
                end
                else if (mul_count == '0)
                    state_next = ST_ADDC;
                else
                    state_next = ST_CMUL;
            end

            // p = p * z, four shifted real products summed and clamped
            ST_CMUL:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        mul_req.a  = OPND_W'(pr_reg);
                        mul_req.b  = OPND_W'(zr_reg);
                        phase_next = 3'd1;
                    end
                    3'd1:
                    begin
                        mul_req.a  = OPND_W'(pi_reg);
                        mul_req.b  = OPND_W'(zi_reg);
                        acc_next   = prod_sx;
                        phase_next = 3'd2;
                    end
                    3'd2:
                    begin
                        mul_req.a   = OPND_W'(pr_reg);
                        mul_req.b   = OPND_W'(zi_reg);
                        re_tmp_next = sat32(acc_reg - prod_sx);
                        phase_next  = 3'd3;
                    end
                    3'd3:
                    begin
                        mul_req.a  = OPND_W'(pi_reg);
                        mul_req.b  = OPND_W'(zr_reg);
                        acc_next   = prod_sx;
                        phase_next = 3'd4;
                    end
                    default:
                    begin
                        pr_next     = re_tmp_reg;
                        pi_next     = sat32(acc_reg + prod_sx);
                        pcount_next = pcount_reg - PCNT_W'(1);
                        phase_next  = '0;
                        if (pcount_reg == PCNT_W'(1))
                            state_next = ST_ADDC;
                    end
                endcase
            end

            // z = p + c
            ST_ADDC:
            begin
                zr_next    = sat32(SUM_W'(pr_reg) + SUM_W'(cr_reg));
                zi_next    = sat32(SUM_W'(pi_reg) + SUM_W'(ci_reg));
                iter_next  = iter_reg + LIMIT_BITS'(1);
                phase_next = '0;
                state_next = ST_MAG;
            end

            // |z|^2 as the sum of two shifted squares, not clamped
            ST_MAG:
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        mul_req.a  = OPND_W'(zr_reg);
                        mul_req.b  = OPND_W'(zr_reg);
                        phase_next = 3'd1;
                    end
                    3'd1:
                    begin
                        mul_req.a  = OPND_W'(zi_reg);
                        mul_req.b  = OPND_W'(zi_reg);
                        acc_next   = prod_sx;
                        phase_next = 3'd2;
                    end
                    default:
                    begin
                        mag_next   = acc_reg + prod_sx;
                        phase_next = '0;
                        state_next = ST_CHECK;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign iter_count       = iter_count_reg;
    assign escaped          = escaped_reg;
    assign excess_magnitude = excess_reg;

    // checks on the sequencer and result word
    `MBET_ASSERT_NXT(a_start_busy, start && !busy, busy,
        "accepted pixel did not make the block busy")
    `MBET_ASSERT_NXT(a_done_single, done, !done,
        "result strobe lasted more than one cycle")
    `MBET_ASSERT_IMP(a_escaped_excess, done && escaped, !excess_magnitude[WORD_W-1],
        "escaped result with negative excess magnitude")
    `MBET_ASSERT_IMP(a_limit_count, done && !escaped, iter_count == 16'(limit),
        "non-escaped result did not run to the iteration limit")

endmodule

// ===== tb/escape_time_checker.sv =====
// checker for the multibrot escape-time block: predicts each pixel's escape result and compares
module escape_time_checker
    import mbet_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [PIXEL_BITS-1:0]    pixel_col,
    input  logic [PIXEL_BITS-1:0]    pixel_row,
    input  logic                     done,
    input  logic [15:0]              iter_count,
    input  logic                     escaped,
    input  logic signed [WORD_W-1:0] excess_magnitude,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    output int                       fail_count,
    output int                       pending_count
);

    localparam longint FOUR_FIX  = longint'(4) << FRAC_BITS;
    localparam longint WORD_HIGH = (longint'(1) << (WORD_W - 1)) - 1;
    localparam longint WORD_LOW  = -(longint'(1) << (WORD_W - 1));

    typedef struct {
        logic [15:0]              count;
        logic                     esc;
        logic signed [WORD_W-1:0] excess;
    } escape_t;

    // shadow copy of the configuration registers
    logic signed [WORD_W-1:0] min_re, min_im;
    logic [STEP_W-1:0]        step_re, step_im;
    logic [LIMIT_REG_W-1:0]   limit_shadow;
    logic [EXP_W-1:0]         power_reg;

    escape_t expected_escapes[$];
    int      mismatches = 0;

    // clamp to the signed 32-bit range
    function automatic longint clamp_word(longint v);
        if (v > WORD_HIGH)
            return WORD_HIGH;
        if (v < WORD_LOW)
            return WORD_LOW;
        return v;
    endfunction

    // exact product, scaled back by the fraction bits, rounded toward minus infinity
    function automatic longint fix_mul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    // escape-time iteration for one pixel under the current registers
    function automatic escape_t predict_escape(logic [PIXEL_BITS-1:0] col,
                                               logic [PIXEL_BITS-1:0] row);
        escape_t r;
        longint  cr, ci, zr, zi, pr, pi, tr, mag;
        int      power, count, k;
        power = int'(power_reg);
        if (power == 0)
            power = 1;
        else if (power > MAX_POWER)
            power = MAX_POWER;
        cr = clamp_word(longint'(min_re) + longint'(col) * longint'(step_re));
        ci = clamp_word(longint'(min_im) + longint'(row) * longint'(step_im));
        zr = 0;
        zi = 0;
        mag = 0;
        count = 0;
        while (mag < FOUR_FIX && count < int'(limit_shadow))
        begin
            // z^power by repeated complex multiply, saturating each step
            pr = zr;
            pi = zi;
            for (k = 1; k < power; k++)
            begin
                tr = clamp_word(fix_mul(pr, zr) - fix_mul(pi, zi));
                pi = clamp_word(fix_mul(pr, zi) + fix_mul(pi, zr));
                pr = tr;
            end
            zr = clamp_word(pr + cr);
            zi = clamp_word(pi + ci);
            count++;
            mag = fix_mul(zr, zr) + fix_mul(zi, zi);
        end
        r.count  = 16'(count);
        r.esc    = (mag >= FOUR_FIX);
        r.excess = WORD_W'(clamp_word(mag - FOUR_FIX));
        return r;
    endfunction

    task automatic report_field(string field, longint want_v, longint got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        escape_t want;
        if (!rst_n)
        begin
            min_re       = RST_REAL_MIN;
            min_im       = RST_IMAG_MIN;
            step_re      = RST_STEP;
            step_im      = RST_STEP;
            limit_shadow = RST_LIMIT;
            power_reg    = RST_EXPONENT;
        end
        else
        begin
            // result word: compare with the oldest pixel still outstanding
            if (done)
            begin
                if (expected_escapes.size() == 0)
                begin
                    $display("%0t: result word with no pixel outstanding, %s %0d %0d %0d",
                             $time, "expected none, actual", iter_count, escaped,
                             excess_magnitude);
                    mismatches++;
                end
                else
                begin
                    want = expected_escapes.pop_front();
                    if (iter_count !== want.count)
                        report_field("iter_count", longint'(want.count),
                                     longint'(iter_count));
                    if (escaped !== want.esc)
                        report_field("escaped", longint'(want.esc), longint'(escaped));
                    if (excess_magnitude !== want.excess)
                        report_field("excess_magnitude", longint'(want.excess),
                                     longint'(excess_magnitude));
                end
            end
            // pixel word taken: predict with the registers as they stand
            if (start && !busy)
                expected_escapes.push_back(predict_escape(pixel_col, pixel_row));
            // configuration word
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_REAL_MIN:   min_re       = cfg_data;
                    REG_IMAG_MIN:   min_im       = cfg_data;
                    REG_REAL_STEP:  step_re      = cfg_data[STEP_W-1:0];
                    REG_IMAG_STEP:  step_im      = cfg_data[STEP_W-1:0];
                    REG_ITER_LIMIT: limit_shadow = cfg_data[LIMIT_REG_W-1:0];
                    REG_EXPONENT:   power_reg    = cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_escapes.size();
    end

endmodule

// ===== tb/multibrot_escape_time_test.sv =====
// testbench top for the multibrot escape-time block: pixel and register stimulus, verdict
module multibrot_escape_time_test;
    import mbet_pkg::*;

    localparam int STALL_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ONE_Q         = 1 << FRAC_BITS;
    localparam int MAX_PIXEL     = (1 << PIXEL_BITS) - 1;

    localparam logic [WORD_W-1:0] DEF_STEP = WORD_W'(RST_STEP);
    localparam logic [WORD_W-1:0] DEF_EXP  = WORD_W'(RST_EXPONENT);

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [PIXEL_BITS-1:0]    pixel_col;
    logic [PIXEL_BITS-1:0]    pixel_row;
    logic                     done;
    logic [15:0]              iter_count;
    logic                     escaped;
    logic signed [WORD_W-1:0] excess_magnitude;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [WORD_W-1:0]        cfg_data;
    int                       fail_count;
    int                       pending_count;
    int                       idle_pct;
    int                       idle_levels [3] = '{0, 76, 13};

    multibrot_escape_time dut (.*);

    escape_time_checker checker_inst (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // send one pixel word, with random gaps before it
    task automatic send_pixel(input int col, input int row);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        pixel_col <= PIXEL_BITS'(col);
        pixel_row <= PIXEL_BITS'(row);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every outstanding pixel has reported, then let the block settle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all six registers back to back
    task automatic program_window(input logic [WORD_W-1:0] rmin, input logic [WORD_W-1:0] imin,
                                  input logic [WORD_W-1:0] rstep, input logic [WORD_W-1:0] istep,
                                  input logic [WORD_W-1:0] lim, input logic [WORD_W-1:0] expo);
        logic [CFG_IDX_W-1:0] regs [6];
        logic [WORD_W-1:0]    vals [6];
        regs = '{REG_REAL_MIN, REG_IMAG_MIN, REG_REAL_STEP, REG_IMAG_STEP,
                 REG_ITER_LIMIT, REG_EXPONENT};
        vals = '{rmin, imin, rstep, istep, lim, expo};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // random window: mostly near the main cardioid, sometimes raw noise with small limits and exponents
    task automatic randomize_window(input bit noisy);
        int                rmin, imin;
        logic [WORD_W-1:0] rstep, istep, lim, expo;
        if (noisy)
        begin
            rmin  = $urandom;
            imin  = $urandom;
            rstep = $urandom;
            istep = $urandom;
            lim   = ($urandom & 32'hFFFF_0000) | $urandom_range(1, 12);
            expo  = ($urandom & 32'hFFFF_FF80) | $urandom_range(0, 8);
        end
        else
        begin
            rmin  = RST_REAL_MIN + int'($urandom_range(0, ONE_Q)) - ONE_Q / 2;
            imin  = RST_IMAG_MIN + int'($urandom_range(0, ONE_Q)) - ONE_Q / 2;
            rstep = $urandom_range(1 << 14, 1 << 19);
            istep = $urandom_range(1 << 14, 1 << 19);
            // high powers only with a short iteration budget
            if ($urandom_range(3) == 0)
            begin
                expo = $urandom_range(7, MAX_POWER);
                lim  = $urandom_range(1, 4);
            end
            else
            begin
                expo = $urandom_range(1, 5);
                lim  = $urandom_range(1, 64);
            end
        end
        program_window(rmin, imin, rstep, istep, lim, expo);
    endtask

    // stall watchdog: nothing accepted for too long ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel_col = '0;
        pixel_row = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_REAL_MIN;
        cfg_data  = '0;
        idle_pct  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners and center under the reset window
        send_pixel(0, 0);
        send_pixel(MAX_PIXEL, MAX_PIXEL);
        send_pixel(0, MAX_PIXEL);
        send_pixel(MAX_PIXEL, 0);
        send_pixel(2048, 2048);
        send_pixel(1536, 2048);
        drain_results();

        // zero iteration limit: z never moves
        program_window(RST_REAL_MIN, RST_IMAG_MIN, DEF_STEP, DEF_STEP, 0, DEF_EXP);
        send_pixel(777, 3001);
        drain_results();

        // exponent zero acts as one
        program_window(RST_REAL_MIN, RST_IMAG_MIN, DEF_STEP, DEF_STEP, 20, 0);
        send_pixel(2048, 2048);
        send_pixel(1024, 3000);
        drain_results();

        // exponent above the cap, then right at the cap
        program_window(RST_REAL_MIN, RST_IMAG_MIN, DEF_STEP, DEF_STEP, 3, 127);
        send_pixel(2048, 2048);
        send_pixel(3000, 1000);
        drain_results();
        program_window(RST_REAL_MIN, RST_IMAG_MIN, DEF_STEP, DEF_STEP, 3, MAX_POWER);
        send_pixel(1800, 2300);
        send_pixel(MAX_PIXEL, 0);
        drain_results();

        // linear walk with exponent one
        program_window(RST_REAL_MIN, RST_IMAG_MIN, DEF_STEP, DEF_STEP, 30, 1);
        send_pixel(2049, 2047);
        send_pixel(100, 4000);
        drain_results();

        // coordinate extremes with the largest limit; every point escapes at once
        program_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h0000_FFFF, DEF_EXP);
        send_pixel(0, 0);
        send_pixel(MAX_PIXEL, 1);
        drain_results();
        program_window(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                       32'h0000_FFFF, DEF_EXP);
        send_pixel(1, 0);
        send_pixel(MAX_PIXEL, MAX_PIXEL);
        drain_results();

        // zero step: every pixel lands on the same point
        program_window(32'hF400_0000, 32'h0199_999A, 0, 0, 50, 3);
        send_pixel(0, 0);
        send_pixel(MAX_PIXEL, MAX_PIXEL);
        drain_results();

        // random windows and pixels under each sender idling level
        foreach (idle_levels[p])
        begin
            idle_pct = idle_levels[p];
            repeat (3)
            begin
                drain_results();
                randomize_window($urandom_range(5) == 0);
                repeat (14)
                    send_pixel($urandom_range(MAX_PIXEL), $urandom_range(MAX_PIXEL));
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
